@@ src/hrve_pkg.sv @@
// ============================================================================
// HTTP response value extractor package
// Shared types, register indexes and character codes for the extractor.
// ============================================================================
package hrve_pkg;

    // Stream parameters
    localparam int MAX_KEY_BYTES     = 32;
    localparam int STATUS_LINE_BYTES = 12;
    localparam int KEY_WORDS         = 4;
    localparam int KEY_BITS          = KEY_WORDS * 64;
    localparam int KEY_SEL_W         = 5;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_DIGITS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_A   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_B   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_C   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_D   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE_LEN = 3'd6;
    localparam int CFG_DATA_W = 64;

    // Register reset values
    localparam logic [23:0] STATUS_DIGITS_RST = 24'h323030;
    localparam logic [15:0] MAX_VALUE_LEN_RST = 16'hFFFF;

    // Character codes
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_EQ = 8'h3D;

    // Parser phase
    typedef enum logic [2:0] {
        PH_STATUS  = 3'd0,
        PH_HEADERS = 3'd1,
        PH_KEY     = 3'd2,
        PH_EQUALS  = 3'd3,
        PH_VALUE   = 3'd4,
        PH_IGNORE  = 3'd5
    } phase_t;

    // Input request payload
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } in_t;

    // Result request payload
    typedef struct packed {
        logic [7:0]  value_byte;
        logic        value_valid;
        logic        done_res;
        logic        status_ok;
        logic [15:0] value_length;
    } out_t;

endpackage

@@ src/hrve_parse.sv @@
// ============================================================================
// HTTP response parser core
// Holds the configuration registers and stream state, and turns one response
// byte into at most one result in the cycle the byte is accepted.
// ============================================================================
module hrve_parse
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hrve_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hrve_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               step,
    input  hrve_pkg::in_t                      in_data,
    output logic                               res_present,
    output hrve_pkg::out_t                     res_data
);
    import hrve_pkg::*;

    // Configuration registers
    logic [23:0]         status_digits_reg;
    logic [5:0]          key_length_reg;
    logic [KEY_BITS-1:0] key_vec_reg;
    logic [15:0]         max_value_len_reg;

    // Stream state
    phase_t      phase_reg, phase_next;
    logic [3:0]  status_index_reg, status_index_next;
    logic        status_match_reg, status_match_next;
    logic [2:0]  line_end_run_reg, line_end_run_next;
    logic [5:0]  key_position_reg, key_position_next;
    logic [15:0] value_count_reg, value_count_next;

    logic [5:0]  klen;
    logic [7:0]  key_char;
    logic [7:0]  rx;
    logic        last;

    assign rx   = in_data.rx_byte;
    assign last = in_data.last_byte;

    // Effective key length is clamped to the key store size.
    assign klen = (key_length_reg > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length_reg;

    // Key byte at the current match position.
    assign key_char = key_vec_reg[key_position_reg[KEY_SEL_W-1:0] * 8 +: 8];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_digits_reg <= STATUS_DIGITS_RST;
            key_length_reg    <= '0;
            key_vec_reg       <= '0;
            max_value_len_reg <= MAX_VALUE_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STATUS_DIGITS: status_digits_reg <= cfg_data[23:0];
                CFG_KEY_LENGTH:    key_length_reg    <= cfg_data[5:0];
                CFG_KEY_BYTES_A:   key_vec_reg[0*64 +: 64] <= cfg_data;
                CFG_KEY_BYTES_B:   key_vec_reg[1*64 +: 64] <= cfg_data;
                CFG_KEY_BYTES_C:   key_vec_reg[2*64 +: 64] <= cfg_data;
                CFG_KEY_BYTES_D:   key_vec_reg[3*64 +: 64] <= cfg_data;
                CFG_MAX_VALUE_LEN: max_value_len_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Stream state register, advanced once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_STATUS;
            status_index_reg <= '0;
            status_match_reg <= 1'b1;
            line_end_run_reg <= '0;
            key_position_reg <= '0;
            value_count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            status_index_reg <= status_index_next;
            status_match_reg <= status_match_next;
            line_end_run_reg <= line_end_run_next;
            key_position_reg <= key_position_next;
            value_count_reg  <= value_count_next;
        end
    end

    // Per-byte parse step and result formation.
    always_comb
    begin
        logic [7:0] want;
        logic       check;
        logic       consumed;
        logic       emit;
        logic       ok;

        phase_next        = phase_reg;
        status_index_next = status_index_reg;
        status_match_next = status_match_reg;
        line_end_run_next = line_end_run_reg;
        key_position_next = key_position_reg;
        value_count_next  = value_count_reg;
        want              = 8'h00;
        check             = 1'b0;
        consumed          = 1'b0;
        emit              = 1'b0;

        unique case (phase_reg) inside
            PH_STATUS:
            begin
                // Only the three status digits are compared.
                case (status_index_reg)
                    4'd9:
                    begin
                        want  = status_digits_reg[23:16];
                        check = 1'b1;
                    end
                    4'd10:
                    begin
                        want  = status_digits_reg[15:8];
                        check = 1'b1;
                    end
                    4'd11:
                    begin
                        want  = status_digits_reg[7:0];
                        check = 1'b1;
                    end
                    default: ;
                endcase
                if (check && (rx != want))
                begin
                    status_match_next = 1'b0;
                end
                status_index_next = status_index_reg + 4'd1;
                if (status_index_next >= 4'(STATUS_LINE_BYTES))
                begin
                    phase_next = status_match_next ? PH_HEADERS : PH_IGNORE;
                end
            end
            PH_HEADERS:
            begin
                // A run of four line-end bytes ends the headers.
                if ((rx == CH_CR) || (rx == CH_LF))
                begin
                    line_end_run_next = line_end_run_reg + 3'd1;
                end
                else
                begin
                    line_end_run_next = '0;
                end
                if (line_end_run_next >= 3'd4)
                begin
                    phase_next = PH_KEY;
                end
            end
            PH_KEY, PH_EQUALS, PH_VALUE:
            begin
                // Naive key match: a mismatch restarts at key byte zero.
                if (phase_reg == PH_KEY)
                begin
                    if (key_position_reg < klen)
                    begin
                        if (rx == key_char)
                        begin
                            key_position_next = key_position_reg + 6'd1;
                        end
                        else
                        begin
                            key_position_next = '0;
                        end
                        consumed = 1'b1;
                    end
                    if (key_position_next >= klen)
                    begin
                        phase_next = PH_EQUALS;
                    end
                end
                // One optional equals sign after the key.
                if (!consumed && (phase_next == PH_EQUALS))
                begin
                    phase_next = PH_VALUE;
                    if (rx == CH_EQ)
                    begin
                        consumed = 1'b1;
                    end
                end
                // Value bytes up to the configured limit.
                if (!consumed && (phase_next == PH_VALUE))
                begin
                    if (value_count_reg < max_value_len_reg)
                    begin
                        value_count_next = value_count_reg + 16'd1;
                        emit             = 1'b1;
                    end
                end
            end
            PH_IGNORE: ;
            default: ;
        endcase

        ok = (status_index_next >= 4'(STATUS_LINE_BYTES)) && status_match_next;

        res_present           = step && (emit || last);
        res_data.value_byte   = emit ? rx : 8'h00;
        res_data.value_valid  = emit;
        res_data.done_res     = last;
        res_data.status_ok    = last && ok;
        res_data.value_length = value_count_next;

        // The last byte returns the stream to its starting state.
        if (last)
        begin
            phase_next        = PH_STATUS;
            status_index_next = '0;
            status_match_next = 1'b1;
            line_end_run_next = '0;
            key_position_next = '0;
            value_count_next  = '0;
        end
    end

`ifndef SYNTHESIS
    // A header line-end run never passes four.
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_end_run_reg <= 3'd4)
        else $error("line-end run exceeded four");

    // Past the status line the status index sits at its final count.
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_STATUS) |-> (status_index_reg == 4'(STATUS_LINE_BYTES)))
        else $error("status index incomplete outside status phase");

    // The key position never runs beyond the key store.
    a_key_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_position_reg <= 6'(MAX_KEY_BYTES))
        else $error("key position beyond key store");

    // A last byte always leaves the stream at the status line start.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> ((phase_reg == PH_STATUS) && (status_index_reg == 4'd0)
                            && (value_count_reg == 16'd0)))
        else $error("stream state not cleared after last byte");
`endif

endmodule

@@ src/http_response_value_extract.sv @@
// ============================================================================
// HTTP response value extractor
// Parses a response byte stream, checks the status code, finds a key in the
// body and returns the value bytes that follow it.
// ============================================================================
// One response byte is taken per clock cycle, every cycle that input stall is
// low. Its result (if any) is presented on the output in the cycle after the byte
// is accepted when the output register is free or is being taken that cycle;
// otherwise it waits in the skid entry until the output register drains. The
// whole parse step for a byte is a single pass of compares and counter
// updates between the accepted byte and the output register. The output
// side has two result entries (output register plus a skid entry), so input
// stall rises only when both hold results that the downstream has not taken.
// Configuration must be written through the plain write port only while no
// response is in flight; the block itself does not enforce this.
module http_response_value_extract
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hrve_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hrve_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  hrve_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output hrve_pkg::out_t                     out_data
);
    import hrve_pkg::*;

    logic   step;
    logic   res_present;
    out_t   res_data;
    logic   take_out;

    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    out_t   out_data_reg, out_data_next;
    out_t   skid_data_reg, skid_data_next;

    assign in_stall  = skid_valid_reg;
    assign step      = in_valid && !in_stall;
    assign take_out  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Parser core.
    hrve_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (step),
        .in_data     (in_data),
        .res_present (res_present),
        .res_data    (res_data)
    );

    // Output register and skid entry steering.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (take_out)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        // A new result fills the output register if it is empty or frees up, else the skid.
        if (res_present)
        begin
            if (!out_valid_reg || take_out)
            begin
                out_data_next  = res_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    // The skid entry is only occupied behind a full output register.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result with output register empty");

    // A result arriving at a blocked output lands in the skid entry.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (res_present && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result lost at blocked output");

    // Status is only reported together with the done flag.
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status_ok) |-> out_data_reg.done_res)
        else $error("status reported without done");

    // Every presented result carries a value byte or the done flag.
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.value_valid || out_data_reg.done_res))
        else $error("empty result presented");
`endif

endmodule

@@ sim/value_extract_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Value extractor checker
// Watches the configuration port and both request channels of the HTTP
// response value extractor, tracks the parse of each accepted byte and
// compares every result request, field by field, with the oldest expected one.
// ============================================================================
module value_extract_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hrve_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hrve_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  hrve_pkg::in_t                      in_data,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  hrve_pkg::out_t                     out_data,
    output int                                 mismatches,
    output int                                 outstanding
);
    import hrve_pkg::*;

    // Shadow copies of the configuration registers
    logic [23:0] want_digits;
    logic [5:0]  key_len_reg;
    logic [63:0] key_word [KEY_WORDS];
    logic [15:0] value_limit;

    // Parse state of the response in flight
    phase_t      parse_phase;
    int          status_pos;
    bit          status_good;
    int          crlf_run;
    int          key_pos;
    logic [15:0] value_count;

    // Results still owed by the block, oldest first
    out_t        expected_values [$];

    // Key byte at a match position; the low five bits select the byte.
    function automatic logic [7:0] key_char(input int pos);
        logic [4:0] sel;
        sel = 5'(pos);
        return key_word[sel[4:3]][sel[2:0]*8 +: 8];
    endfunction

    // Return the stream state to its idle values after the final byte.
    function automatic void clear_stream();
        parse_phase = PH_STATUS;
        status_pos  = 0;
        status_good = 1'b1;
        crlf_run    = 0;
        key_pos     = 0;
        value_count = '0;
    endfunction

    // Advance the parse by one byte and queue the result it causes, if any.
    function automatic void track_response_byte(input in_t req);
        int          klen;
        bit          emit;
        bit          used;
        bit          check;
        logic [7:0]  b;
        logic [7:0]  want;
        out_t        rep;
        b    = req.rx_byte;
        emit = 1'b0;
        used = 1'b0;
        want = 8'h00;
        klen = (key_len_reg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len_reg);
        case (parse_phase)
            PH_STATUS:
            begin
                // Only the three status digits are compared.
                check = 1'b1;
                if (status_pos == 9)
                    want = want_digits[23:16];
                else if (status_pos == 10)
                    want = want_digits[15:8];
                else if (status_pos == 11)
                    want = want_digits[7:0];
                else
                    check = 1'b0;
                if (check && b != want)
                    status_good = 1'b0;
                status_pos++;
                if (status_pos >= STATUS_LINE_BYTES)
                    parse_phase = status_good ? PH_HEADERS : PH_IGNORE;
            end
            PH_HEADERS:
            begin
                // Four line-end bytes in a row close the header section.
                if (b == CH_CR || b == CH_LF)
                    crlf_run++;
                else
                    crlf_run = 0;
                if (crlf_run >= 4)
                    parse_phase = PH_KEY;
            end
            PH_KEY, PH_EQUALS, PH_VALUE:
            begin
                // A byte that breaks the key match restarts it and is dropped.
                if (parse_phase == PH_KEY)
                begin
                    if (key_pos < klen)
                    begin
                        if (b == key_char(key_pos))
                            key_pos++;
                        else
                            key_pos = 0;
                        used = 1'b1;
                    end
                    if (key_pos >= klen)
                        parse_phase = PH_EQUALS;
                end
                if (!used && parse_phase == PH_EQUALS)
                begin
                    parse_phase = PH_VALUE;
                    used = (b == CH_EQ);
                end
                if (!used && parse_phase == PH_VALUE && value_count < value_limit)
                begin
                    value_count++;
                    emit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (emit || req.last_byte)
        begin
            rep.value_byte   = emit ? b : 8'h00;
            rep.value_valid  = emit;
            rep.done_res     = req.last_byte;
            rep.status_ok    = req.last_byte && status_pos >= STATUS_LINE_BYTES && status_good;
            rep.value_length = value_count;
            expected_values.push_back(rep);
            if (req.last_byte)
                clear_stream();
        end
    endfunction

    // Compare one result request with the oldest expected one.
    function automatic void compare_result(input out_t got);
        out_t want_r;
        if (expected_values.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("checker: %0t unexpected result byte %h valid %b done %b ok %b len %0d",
                         $time, got.value_byte, got.value_valid, got.done_res,
                         got.status_ok, got.value_length);
            return;
        end
        want_r = expected_values.pop_front();
        if (got.value_byte !== want_r.value_byte || got.value_valid !== want_r.value_valid ||
            got.done_res !== want_r.done_res || got.status_ok !== want_r.status_ok ||
            got.value_length !== want_r.value_length)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("checker: %0t expected byte %h valid %b done %b ok %b len %0d",
                         $time, want_r.value_byte, want_r.value_valid, want_r.done_res,
                         want_r.status_ok, want_r.value_length);
                $display("checker: %0t actual   byte %h valid %b done %b ok %b len %0d",
                         $time, got.value_byte, got.value_valid, got.done_res,
                         got.status_ok, got.value_length);
            end
        end
    endfunction

    // Sample the port and both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_digits = STATUS_DIGITS_RST;
            key_len_reg = '0;
            for (int w = 0; w < KEY_WORDS; w++)
                key_word[w] = '0;
            value_limit = MAX_VALUE_LEN_RST;
            clear_stream();
            expected_values.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STATUS_DIGITS: want_digits = cfg_data[23:0];
                    CFG_KEY_LENGTH:    key_len_reg = cfg_data[5:0];
                    CFG_KEY_BYTES_A:   key_word[0] = cfg_data;
                    CFG_KEY_BYTES_B:   key_word[1] = cfg_data;
                    CFG_KEY_BYTES_C:   key_word[2] = cfg_data;
                    CFG_KEY_BYTES_D:   key_word[3] = cfg_data;
                    CFG_MAX_VALUE_LEN: value_limit = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                track_response_byte(in_data);
            if (out_valid && !out_stall)
                compare_result(out_data);
        end
        outstanding = expected_values.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Value extractor testbench
// Feeds HTTP responses byte by byte into the extractor under random idling on
// both channels, rewrites its registers between groups of responses and lets
// the checker judge every result request.
// ============================================================================
module testbench;
    import hrve_pkg::*;

    localparam int         RANDOM_BYTES  = 1750;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         SETTLE_CYCLES = 6;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_t                    in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_t                   out_data;
    int                     mismatches;
    int                     outstanding;

    // Stimulus control
    bit                     idle_on;
    bit                     hold_long;
    int                     sent_bytes;

    // Register values as last chosen, used to build matching responses
    logic [23:0]            digit_cfg;
    int                     key_len_cfg;
    logic [7:0]             key_chars [MAX_KEY_BYTES];
    int                     value_limit;

    // Bytes of the response being built
    logic [7:0]             resp_q [$];

    http_response_value_extract uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    value_extract_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog against a hung run
    initial
    begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    // Result side: random stall bursts, and one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_long = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one byte, with an occasional gap first, and wait for acceptance.
    task automatic send_req(input logic [7:0] b, input bit last);
        if (idle_on && !hold_long && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent_bytes++;
    endtask

    // Send the built bytes; the final one closes the response if asked.
    task automatic send_stream(input bit closes);
        for (int i = 0; i < resp_q.size(); i++)
            send_req(resp_q[i], closes && (i == resp_q.size() - 1));
    endtask

    // Wait until every owed result has come and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    function automatic logic [63:0] key_word(input int w);
        logic [63:0] word;
        for (int j = 0; j < 8; j++)
            word[8*j +: 8] = key_chars[8*w + j];
        return word;
    endfunction

    // Write all registers from the current choices.
    task automatic load_settings();
        put_reg(CFG_STATUS_DIGITS, 64'(digit_cfg));
        put_reg(CFG_KEY_LENGTH, 64'(key_len_cfg));
        put_reg(CFG_KEY_BYTES_A, key_word(0));
        put_reg(CFG_KEY_BYTES_B, key_word(1));
        put_reg(CFG_KEY_BYTES_C, key_word(2));
        put_reg(CFG_KEY_BYTES_D, key_word(3));
        put_reg(CFG_MAX_VALUE_LEN, 64'(value_limit));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_key(input string s);
        key_len_cfg = s.len();
        for (int i = 0; i < s.len(); i++)
            key_chars[i] = s[i];
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            resp_q.push_back(s[i]);
    endtask

    task automatic push_crlf();
        resp_q.push_back(CH_CR);
        resp_q.push_back(CH_LF);
    endtask

    // Status line with the configured digits and an empty header section.
    task automatic push_good_head();
        push_text("HTTP/1.1 ");
        resp_q.push_back(digit_cfg[23:16]);
        resp_q.push_back(digit_cfg[15:8]);
        resp_q.push_back(digit_cfg[7:0]);
        push_crlf();
        push_crlf();
    endtask

    // Pick new register values, leaning toward short keys and the extremes.
    task automatic pick_settings();
        int pick;
        bit narrow;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            digit_cfg = STATUS_DIGITS_RST;
        else if (pick < 75)
            digit_cfg = {8'(CH_ZERO + $urandom_range(0, 9)), 8'(CH_ZERO + $urandom_range(0, 9)),
                         8'(CH_ZERO + $urandom_range(0, 9))};
        else if (pick < 85)
            digit_cfg = 24'h000000;
        else if (pick < 95)
            digit_cfg = 24'hFFFFFF;
        else
            digit_cfg = 24'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 20)
            key_len_cfg = 0;
        else if (pick < 60)
            key_len_cfg = $urandom_range(1, 4);
        else if (pick < 85)
            key_len_cfg = $urandom_range(5, 16);
        else if (pick < 95)
            key_len_cfg = $urandom_range(17, MAX_KEY_BYTES);
        else
            key_len_cfg = (pick == 99) ? 63 : $urandom_range(MAX_KEY_BYTES + 1, 63);
        // A narrow alphabet makes the restart after a broken match common.
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            if (narrow)
                key_chars[i] = 8'(CH_LOWER_A + $urandom_range(0, 2));
            else if ($urandom_range(0, 4) == 0)
                key_chars[i] = 8'($urandom_range(0, 255));
            else
                key_chars[i] = 8'(CH_LOWER_A + $urandom_range(0, 25));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
            value_limit = 65535;
        else if (pick < 55)
            value_limit = 0;
        else if (pick < 85)
            value_limit = $urandom_range(1, 8);
        else
            value_limit = $urandom_range(0, 65535);
    endtask

    // Build one random response; most are well formed with random content.
    task automatic make_response();
        int kind;
        int klen;
        int len;
        kind = $urandom_range(0, 99);
        klen = (key_len_cfg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len_cfg;
        resp_q.delete();
        // Status line, sometimes garbled or with wrong digits
        if (kind < 5)
            repeat (9) resp_q.push_back(8'($urandom_range(0, 255)));
        else
            push_text("HTTP/1.1 ");
        if (kind >= 5 && kind < 15)
            repeat (3) resp_q.push_back(8'($urandom_range(0, 255)));
        else
        begin
            resp_q.push_back(digit_cfg[23:16]);
            resp_q.push_back(digit_cfg[15:8]);
            resp_q.push_back(digit_cfg[7:0]);
        end
        // Response cut short inside the status line
        if (kind >= 95)
        begin
            len = $urandom_range(1, STATUS_LINE_BYTES);
            while (resp_q.size() > len)
                resp_q.delete(resp_q.size() - 1);
            return;
        end
        // Header lines with occasional stray bytes
        len = $urandom_range(0, 3);
        repeat (len)
        begin
            repeat ($urandom_range(0, 10))
            begin
                if ($urandom_range(0, 9) == 0)
                    resp_q.push_back(8'($urandom_range(0, 255)));
                else
                    resp_q.push_back(8'($urandom_range(32, 126)));
            end
            push_crlf();
        end
        if (kind >= 90)
        begin
            // Header section never closed
            repeat ($urandom_range(1, 8))
                resp_q.push_back(8'($urandom_range(32, 126)));
        end
        else
        begin
            push_crlf();
            if (len == 0)
                push_crlf();
        end
        // Body: partial keys and noise, then key, optional '=' and the value
        repeat ($urandom_range(0, 4))
        begin
            if (klen > 0 && $urandom_range(0, 1) == 1)
            begin
                len = $urandom_range(1, klen);
                for (int i = 0; i < len; i++)
                    resp_q.push_back(key_chars[i]);
            end
            else
            begin
                resp_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) < 8)
            for (int i = 0; i < klen; i++)
                resp_q.push_back(key_chars[i]);
        if ($urandom_range(0, 9) < 7)
            resp_q.push_back(CH_EQ);
        repeat ($urandom_range(0, 20))
            resp_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
        begin
            resp_q.push_back(CH_AMP);
            repeat ($urandom_range(1, 6))
                resp_q.push_back(8'($urandom_range(32, 126)));
        end
    endtask

    // Main stimulus
    initial
    begin
        int target;
        int responses;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_STATUS_DIGITS;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        idle_on     = 1'b1;
        hold_long   = 1'b0;
        sent_bytes  = 0;
        digit_cfg   = STATUS_DIGITS_RST;
        key_len_cfg = 0;
        value_limit = 65535;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
            key_chars[i] = 8'h00;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings, empty key: the first body byte is the '=' test.
        resp_q.delete();
        push_good_head();
        resp_q.push_back(CH_EQ);
        resp_q.push_back(8'h00);
        resp_q.push_back(8'hFF);
        send_stream(1'b1);

        // Response that ends inside the status line
        resp_q.delete();
        resp_q.push_back(8'hFF);
        resp_q.push_back(8'h00);
        resp_q.push_back(8'h80);
        send_stream(1'b1);

        // Wrong status digits: the rest is ignored.
        resp_q.delete();
        push_text("HTTP/1.1 201");
        push_crlf();
        push_crlf();
        push_text("xy");
        send_stream(1'b1);

        // Broken key match restarts without retesting; limit of one value byte.
        settle();
        set_key("ab");
        value_limit = 1;
        load_settings();
        resp_q.delete();
        push_good_head();
        push_text("aababxy");
        send_stream(1'b1);

        // Key shortened while a match is under way.
        settle();
        set_key("abc");
        value_limit = 65535;
        load_settings();
        resp_q.delete();
        push_good_head();
        push_text("ab");
        send_stream(1'b0);
        settle();
        key_len_cfg = 1;
        load_settings();
        resp_q.delete();
        push_text("Zq");
        send_stream(1'b1);

        // Long hold-off on the result side while value bytes keep coming.
        settle();
        set_key("");
        load_settings();
        resp_q.delete();
        push_good_head();
        repeat (30) resp_q.push_back(8'($urandom_range(0, 255)));
        hold_long = 1'b1;
        send_stream(1'b1);

        // Random responses, new settings every few of them
        target    = sent_bytes + RANDOM_BYTES;
        responses = 0;
        while (sent_bytes < target)
        begin
            if (responses % 4 == 0)
            begin
                settle();
                pick_settings();
                load_settings();
            end
            if (sent_bytes > target - target / 7)
                idle_on = 1'b0;
            make_response();
            send_stream(1'b1);
            responses++;
        end

        settle();
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
